// ===== src/pdtd_pkg.sv =====
`default_nettype none

package pdtd_pkg;

    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int PROD_W  = 2 * CNT_W;
    localparam int STEP_W  = $clog2(PROD_W);
    localparam int TEMP_W  = 16;
    localparam int CLAMP_W = 17;
    localparam int DIFF_W  = CLAMP_W + 1;

    localparam logic [CNT_W-1:0]   MODULUS_RST = 16'd65535;
    localparam logic [CFG_W-1:0]   GAIN_RST    = 16'd21277;
    localparam logic [CFG_W-1:0]   OFFSET_RST  = 16'd6809;
    localparam logic [CLAMP_W-1:0] Q_CLAMP     = 17'd100000;

    localparam logic signed [DIFF_W-1:0] TEMP_MAX = 18'sd32767;
    localparam logic signed [DIFF_W-1:0] TEMP_MIN = -18'sd32768;

    typedef enum logic [1:0] {
        MODE_PULSE  = 2'd0,
        MODE_PERIOD = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    localparam logic [1:0] CFG_MODULUS = 2'd0;
    localparam logic [1:0] CFG_GAIN    = 2'd1;
    localparam logic [1:0] CFG_OFFSET  = 2'd2;

endpackage

`default_nettype wire

// ===== src/pwm_duty_temperature_decoder.sv =====
// Channel   Dir  tdata (low bit up)                 tuser (low bit up)
// s_*       in   capture_time[15:0], pin_level[16]  mode[1:0]
// m_*       out  temperature_centi[15:0]            data_ready[0], divide_fault[1]
// cfg_*     in   cfg_index selects register, cfg_data holds value
//
// A read with complete data and a nonzero period latches the intervals, runs
// 16 shift-add multiply and 32 restoring divide steps, then saturates and
// loads the output; any other read goes straight to loading the output.
// s_tready is low from a read until its result is loaded; capture beats are
// taken while a result waits in m_*.
// Reset clears times, marks and m_tvalid and loads the register defaults.
`default_nettype none

module pwm_duty_temperature_decoder
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,   // capture_time, pin_level, zero fill
    input  wire logic [1:0]                s_tuser,   // mode

    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [15:0]                    m_tdata,   // temperature_centi
    output logic [1:0]                     m_tuser,   // data_ready, divide_fault

    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [pdtd_pkg::CFG_W-1:0] cfg_data
);
    import pdtd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(CNT_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PROD_W - 1);

    function automatic logic [CNT_W-1:0] span(input logic [CNT_W-1:0] s,
                                              input logic [CNT_W-1:0] e,
                                              input logic [CNT_W-1:0] m);
        logic [CNT_W-1:0] d;
        if (e > s)
            d = e - s;
        else
            d = e + m - s;
        return d;
    endfunction

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    logic [CNT_W-1:0]   modulus_reg;
    logic [CFG_W-1:0]   gain_reg, offset_reg;

    logic [CNT_W-1:0]   pulse_start_reg, pulse_start_next;
    logic [CNT_W-1:0]   pulse_end_reg, pulse_end_next;
    logic [CNT_W-1:0]   period_start_reg, period_start_next;
    logic [CNT_W-1:0]   period_end_reg, period_end_next;
    logic               pulse_done_reg, pulse_done_next;
    logic               period_phase_reg, period_phase_next;
    logic               period_done_reg, period_done_next;

    logic               ready_reg, ready_next;
    logic               fault_reg, fault_next;
    logic               out_valid_reg, out_valid_next;

    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   div_reg, div_next;
    logic [TEMP_W-1:0]  temp_reg, temp_next;
    logic [1:0]         flags_reg, flags_next;

    logic               accept;
    mode_t              mode;
    logic [CNT_W-1:0]   cap_time;
    logic               pin;
    logic [CNT_W-1:0]   high_time, period_time;
    logic [CNT_W:0]     mul_sum;
    logic [CNT_W:0]     trial;
    logic               trial_ge;
    logic               out_free;
    logic [CLAMP_W-1:0] q_clamped;
    logic signed [DIFF_W-1:0] diff;
    logic [TEMP_W-1:0]  temp_sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser);
    assign cap_time = s_tdata[CNT_W-1:0];
    assign pin      = s_tdata[CNT_W];

    assign high_time   = span(pulse_start_reg, pulse_end_reg, modulus_reg);
    assign period_time = span(period_start_reg, period_end_reg, modulus_reg);

    assign mul_sum  = {1'b0, prod_reg[PROD_W-1:CNT_W]} +
                      (prod_reg[0] ? {1'b0, gain_reg} : '0);
    assign trial    = {rem_reg, prod_reg[PROD_W-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});

    assign out_free = !out_valid_reg || m_tready;

    assign q_clamped = (prod_reg > PROD_W'(Q_CLAMP)) ? Q_CLAMP : prod_reg[CLAMP_W-1:0];
    assign diff      = $signed({1'b0, q_clamped}) - $signed({2'b00, offset_reg});

    always_comb
    begin
        if (diff > TEMP_MAX)
            temp_sat = TEMP_MAX[TEMP_W-1:0];
        else if (diff < TEMP_MIN)
            temp_sat = TEMP_MIN[TEMP_W-1:0];
        else
            temp_sat = diff[TEMP_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        pulse_start_next  = pulse_start_reg;
        pulse_end_next    = pulse_end_reg;
        period_start_next = period_start_reg;
        period_end_next   = period_end_reg;
        pulse_done_next   = pulse_done_reg;
        period_phase_next = period_phase_reg;
        period_done_next  = period_done_reg;
        ready_next        = ready_reg;
        fault_next        = fault_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        div_next          = div_reg;
        temp_next         = temp_reg;
        flags_next        = flags_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_PULSE:
                        begin
                            pulse_done_next = 1'b0;
                            if (pin)
                                pulse_start_next = cap_time;
                            else
                            begin
                                pulse_end_next  = cap_time;
                                pulse_done_next = 1'b1;
                            end
                        end
                        MODE_PERIOD:
                        begin
                            period_done_next = 1'b0;
                            if (!period_phase_reg)
                            begin
                                period_start_next = cap_time;
                                period_phase_next = 1'b1;
                            end
                            else
                            begin
                                period_end_next   = cap_time;
                                period_phase_next = 1'b0;
                                period_done_next  = 1'b1;
                            end
                        end
                        MODE_READ:
                        begin
                            ready_next = pulse_done_reg && period_done_reg;
                            fault_next = 1'b0;
                            state_next = ST_FIN;
                            if (pulse_done_reg && period_done_reg)
                            begin
                                pulse_start_next  = '0;
                                pulse_end_next    = '0;
                                period_start_next = '0;
                                period_end_next   = '0;
                                pulse_done_next   = 1'b0;
                                period_done_next  = 1'b0;
                                prod_next         = {{CNT_W{1'b0}}, high_time};
                                div_next          = period_time;
                                rem_next          = '0;
                                step_next         = '0;
                                if (period_time == '0)
                                    fault_next = 1'b1;
                                else
                                    state_next = ST_MUL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next = {mul_sum, prod_reg[CNT_W-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = trial_ge ? trial[CNT_W-1:0] - div_reg : trial[CNT_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], trial_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    temp_next      = (ready_reg && !fault_reg) ? temp_sat : '0;
                    flags_next     = {fault_reg, ready_reg};
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            modulus_reg      <= MODULUS_RST;
            gain_reg         <= GAIN_RST;
            offset_reg       <= OFFSET_RST;
            pulse_start_reg  <= '0;
            pulse_end_reg    <= '0;
            period_start_reg <= '0;
            period_end_reg   <= '0;
            pulse_done_reg   <= 1'b0;
            period_phase_reg <= 1'b0;
            period_done_reg  <= 1'b0;
            ready_reg        <= 1'b0;
            fault_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            pulse_start_reg  <= pulse_start_next;
            pulse_end_reg    <= pulse_end_next;
            period_start_reg <= period_start_next;
            period_end_reg   <= period_end_next;
            pulse_done_reg   <= pulse_done_next;
            period_phase_reg <= period_phase_next;
            period_done_reg  <= period_done_next;
            ready_reg        <= ready_next;
            fault_reg        <= fault_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODULUS: modulus_reg <= cfg_data[CNT_W-1:0];
                    CFG_GAIN:    gain_reg    <= cfg_data;
                    CFG_OFFSET:  offset_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        temp_reg  <= temp_next;
        flags_reg <= flags_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = temp_reg;
    assign m_tuser  = flags_reg;

`ifndef SYNTHESIS
    a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && step_reg == MUL_LAST) |=> (state_reg == ST_DIV))
        else $error("multiply did not hand over to divide");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg != '0 && rem_reg < div_reg))
        else $error("divide remainder out of range");

    a_fault_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tdata == '0))
        else $error("fault result without ready or with nonzero temperature");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_READ && pulse_done_reg && period_done_reg)
        |=> (!pulse_done_reg && !period_done_reg && state_reg != ST_IDLE))
        else $error("read did not consume the captured data");
`endif

endmodule

`default_nettype wire
